// ===== rtl/cs2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2_pkg
// Shared types, codes and the microcode program of the CipherSaber-2 unit.
// ----------------------------------------------------------------------------
package cs2_pkg;

  // Sizes of the permutation and the default key store.
  localparam int PERM_DEPTH    = 256;
  localparam int KEY_DEPTH_DEF = 256;
  localparam logic [7:0] IDX_MAX = 8'd255;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] ROUNDS_RST  = 16'd20;
  localparam logic [8:0]  KEY_LEN_RST = 9'd26;

  // Request function codes.
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_SCHED = 2'd1;
  localparam logic [1:0] FN_XFORM = 2'd2;
  localparam logic [1:0] FN_WIPE  = 2'd3;

  // Result kind codes.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_SCHED = 2'd1;
  localparam logic [1:0] KIND_WIPE  = 2'd2;

  // Control word field types.
  typedef enum logic [1:0] {PA_N, PA_I, PA_J, PA_X} paddr_sel_t;
  typedef enum logic [1:0] {PD_IDX, PD_RD, PD_A} pdata_sel_t;
  typedef enum logic [1:0] {J_KEEP, J_ZERO, J_SCHED, J_KS} j_op_t;
  typedef enum logic [1:0] {I_KEEP, I_INC, I_ZERO} i_op_t;
  typedef enum logic [1:0] {N_KEEP, N_ZERO, N_INC} n_op_t;
  typedef enum logic [1:0] {R_KEEP, R_LOAD, R_DEC} r_op_t;
  typedef enum logic [1:0] {EM_NONE, EM_DATA, EM_SCHED, EM_WIPE} emit_t;
  typedef enum logic [1:0] {C_NEXT, C_N_MORE, C_R_ZERO, C_R_MORE} cond_t;

  localparam int PC_W = 5;

  typedef struct packed {
    paddr_sel_t      paddr;
    logic            pwr;
    pdata_sel_t      pdsel;
    logic            ld_a;
    logic            ld_b;
    j_op_t           jop;
    i_op_t           iop;
    n_op_t           nop;
    r_op_t           rop;
    logic            clr;
    logic            kwr;
    emit_t           emit;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ctl_word_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic      en;
    ctl_word_t cw;
  } dp_ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic n_last;
    logic r_zero;
    logic r_one;
  } dp_status_t;

  // Program step addresses.
  localparam logic [PC_W-1:0] ST_S_INIT  = 5'd0;
  localparam logic [PC_W-1:0] ST_S_FILL  = 5'd1;
  localparam logic [PC_W-1:0] ST_S_CHK   = 5'd2;
  localparam logic [PC_W-1:0] ST_S_RDN   = 5'd3;
  localparam logic [PC_W-1:0] ST_S_JUPD  = 5'd4;
  localparam logic [PC_W-1:0] ST_S_RDJ   = 5'd5;
  localparam logic [PC_W-1:0] ST_S_WRN   = 5'd6;
  localparam logic [PC_W-1:0] ST_S_WRJ   = 5'd7;
  localparam logic [PC_W-1:0] ST_S_ROUND = 5'd8;
  localparam logic [PC_W-1:0] ST_S_END   = 5'd9;
  localparam logic [PC_W-1:0] ST_K_INC   = 5'd10;
  localparam logic [PC_W-1:0] ST_K_RDI   = 5'd11;
  localparam logic [PC_W-1:0] ST_K_JUPD  = 5'd12;
  localparam logic [PC_W-1:0] ST_K_RDJ   = 5'd13;
  localparam logic [PC_W-1:0] ST_K_WRI   = 5'd14;
  localparam logic [PC_W-1:0] ST_K_WRJ   = 5'd15;
  localparam logic [PC_W-1:0] ST_K_RDX   = 5'd16;
  localparam logic [PC_W-1:0] ST_K_OUT   = 5'd17;
  localparam logic [PC_W-1:0] ST_WIPE    = 5'd18;
  localparam logic [PC_W-1:0] ST_LOAD    = 5'd19;

  // First program step for each request function.
  function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] fn);
    logic [PC_W-1:0] pc;
    unique case (fn)
      FN_LOAD:  pc = ST_LOAD;
      FN_SCHED: pc = ST_S_INIT;
      FN_XFORM: pc = ST_K_INC;
      FN_WIPE:  pc = ST_WIPE;
    endcase
    return pc;
  endfunction

  // Microcode program. Every step not listed ends the request.
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t cw;
    cw = '0;
    unique case (pc)
      // Key schedule: clear j and n, load the pass counter.
      ST_S_INIT: begin
        cw.jop = J_ZERO;
        cw.nop = N_ZERO;
        cw.rop = R_LOAD;
      end
      // Fill the permutation with the identity.
      ST_S_FILL: begin
        cw.paddr  = PA_N;
        cw.pwr    = 1'b1;
        cw.pdsel  = PD_IDX;
        cw.nop    = N_INC;
        cw.cond   = C_N_MORE;
        cw.target = ST_S_FILL;
      end
      // The fill moved the key pointer, so restart it for the first pass.
      ST_S_CHK: begin
        cw.nop    = N_ZERO;
        cw.cond   = C_R_ZERO;
        cw.target = ST_S_END;
      end
      ST_S_RDN: begin
        cw.paddr = PA_N;
      end
      ST_S_JUPD: begin
        cw.paddr = PA_N;
        cw.ld_a  = 1'b1;
        cw.jop   = J_SCHED;
      end
      ST_S_RDJ: begin
        cw.paddr = PA_J;
      end
      ST_S_WRN: begin
        cw.paddr = PA_N;
        cw.pwr   = 1'b1;
        cw.pdsel = PD_RD;
      end
      ST_S_WRJ: begin
        cw.paddr  = PA_J;
        cw.pwr    = 1'b1;
        cw.pdsel  = PD_A;
        cw.nop    = N_INC;
        cw.cond   = C_N_MORE;
        cw.target = ST_S_RDN;
      end
      ST_S_ROUND: begin
        cw.rop    = R_DEC;
        cw.nop    = N_ZERO;
        cw.cond   = C_R_MORE;
        cw.target = ST_S_RDN;
      end
      ST_S_END: begin
        cw.iop  = I_ZERO;
        cw.jop  = J_ZERO;
        cw.emit = EM_SCHED;
        cw.done = 1'b1;
      end
      // Keystream byte and swap.
      ST_K_INC: begin
        cw.iop = I_INC;
      end
      ST_K_RDI: begin
        cw.paddr = PA_I;
      end
      ST_K_JUPD: begin
        cw.paddr = PA_I;
        cw.ld_a  = 1'b1;
        cw.jop   = J_KS;
      end
      ST_K_RDJ: begin
        cw.paddr = PA_J;
      end
      ST_K_WRI: begin
        cw.paddr = PA_I;
        cw.pwr   = 1'b1;
        cw.pdsel = PD_RD;
        cw.ld_b  = 1'b1;
      end
      ST_K_WRJ: begin
        cw.paddr = PA_J;
        cw.pwr   = 1'b1;
        cw.pdsel = PD_A;
      end
      ST_K_RDX: begin
        cw.paddr = PA_X;
      end
      ST_K_OUT: begin
        cw.paddr = PA_X;
        cw.emit  = EM_DATA;
        cw.done  = 1'b1;
      end
      ST_WIPE: begin
        cw.clr  = 1'b1;
        cw.jop  = J_ZERO;
        cw.emit = EM_WIPE;
        cw.done = 1'b1;
      end
      ST_LOAD: begin
        cw.kwr  = 1'b1;
        cw.done = 1'b1;
      end
      default: begin
        cw.done = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/cs2_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cs2_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cs2_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2_dp
// Datapath: permutation and key memories, indices, pass counter and the
// byte transform, all driven by the control word of the sequencer.
// ----------------------------------------------------------------------------
module cs2_dp #(
  parameter int KEY_DEPTH = cs2_pkg::KEY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  logic [7:0]          in_key_index,
  input  logic [7:0]          in_data,
  input  cs2_pkg::dp_ctl_t    ctl,
  input  logic [15:0]         rounds,
  input  logic [8:0]          key_len,
  output cs2_pkg::dp_status_t status,
  output logic [7:0]          res_byte
);

  import cs2_pkg::*;

  localparam int KAW = $clog2(KEY_DEPTH);

  logic [7:0]      kidx_r, byte_r, a_r, b_r;
  logic [7:0]      i_r, i_nxt, j_r, j_nxt, n_r, n_nxt;
  logic [KAW-1:0]  kptr_r, kptr_nxt;
  logic [15:0]     rnd_r, rnd_nxt;
  logic [PERM_DEPTH-1:0] vld_r;
  logic            rvld_r;
  logic [7:0]      paddr, pwdata, prd_q, pdata, kdata;
  logic            pwe, kwe, in_range, kwrap;
  logic [8:0]      len_eff;

  // Request payload held for the program.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kidx_r <= in_key_index;
      byte_r <= in_data;
    end
  end

  // Permutation address and write data selection.
  always_comb begin
    unique case (ctl.cw.paddr)
      PA_N: paddr = n_r;
      PA_I: paddr = i_r;
      PA_J: paddr = j_r;
      PA_X: paddr = a_r + b_r;
    endcase
  end

  always_comb begin
    case (ctl.cw.pdsel)
      PD_IDX:  pwdata = n_r;
      PD_RD:   pwdata = pdata;
      PD_A:    pwdata = a_r;
      default: pwdata = 8'd0;
    endcase
  end

  assign pwe = ctl.en & ctl.cw.pwr;

  cs2_ram #(.W(8), .D(PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (pwe),
    .waddr (paddr),
    .wdata (pwdata),
    .raddr (paddr),
    .rdata (prd_q)
  );

  // Entries never written since reset or wipe read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[paddr];
      if (ctl.en && ctl.cw.clr) begin
        vld_r <= '0;
      end else if (pwe) begin
        vld_r[paddr] <= 1'b1;
      end
    end
  end

  assign pdata = rvld_r ? prd_q : 8'd0;

  // Key store: loads beyond the store are dropped.
  assign in_range = ({1'b0, kidx_r} < 9'(KEY_DEPTH));
  assign kwe      = ctl.en & ctl.cw.kwr & in_range;

  cs2_ram #(.W(8), .D(KEY_DEPTH)) u_key (
    .clk   (clk),
    .we    (kwe),
    .waddr (kidx_r[KAW-1:0]),
    .wdata (byte_r),
    .raddr (kptr_r),
    .rdata (kdata)
  );

  // Effective key length, clamped to one and to the store depth.
  always_comb begin
    if (key_len == 9'd0) begin
      len_eff = 9'd1;
    end else if (key_len > 9'(KEY_DEPTH)) begin
      len_eff = 9'(KEY_DEPTH);
    end else begin
      len_eff = key_len;
    end
  end

  assign kwrap = ((9'(kptr_r) + 9'd1) == len_eff);

  // Index and counter updates.
  always_comb begin
    case (ctl.cw.jop)
      J_ZERO:  j_nxt = 8'd0;
      J_SCHED: j_nxt = j_r + pdata + kdata;
      J_KS:    j_nxt = j_r + pdata;
      default: j_nxt = j_r;
    endcase

    case (ctl.cw.iop)
      I_INC:   i_nxt = i_r + 8'd1;
      I_ZERO:  i_nxt = 8'd0;
      default: i_nxt = i_r;
    endcase

    case (ctl.cw.nop)
      N_ZERO: begin
        n_nxt    = 8'd0;
        kptr_nxt = '0;
      end
      N_INC: begin
        n_nxt    = n_r + 8'd1;
        kptr_nxt = kwrap ? '0 : kptr_r + 1'b1;
      end
      default: begin
        n_nxt    = n_r;
        kptr_nxt = kptr_r;
      end
    endcase

    case (ctl.cw.rop)
      R_LOAD:  rnd_nxt = rounds;
      R_DEC:   rnd_nxt = rnd_r - 16'd1;
      default: rnd_nxt = rnd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= 8'd0;
      j_r    <= 8'd0;
      n_r    <= 8'd0;
      kptr_r <= '0;
      rnd_r  <= 16'd0;
    end else if (ctl.en) begin
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      n_r    <= n_nxt;
      kptr_r <= kptr_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  // Swap operands held across the program steps.
  always_ff @(posedge clk) begin
    if (ctl.en && ctl.cw.ld_a) begin
      a_r <= pdata;
    end
    if (ctl.en && ctl.cw.ld_b) begin
      b_r <= pdata;
    end
  end

  assign status.n_last = (n_r == IDX_MAX);
  assign status.r_zero = (rnd_r == 16'd0);
  assign status.r_one  = (rnd_r == 16'd1);

  // Data byte XOR keystream byte; acknowledgements carry zero.
  assign res_byte = (ctl.cw.emit == EM_DATA) ? (byte_r ^ pdata) : 8'd0;

endmodule

// ===== rtl/cs2_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2_seq
// Microcode sequencer: dispatches each request to its program, steps the
// program counter, takes conditional jumps and holds on a full result slot.
// ----------------------------------------------------------------------------
module cs2_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  logic [1:0]          in_func,
  input  logic                out_hold,
  input  cs2_pkg::dp_status_t status,
  output logic                in_ready,
  output cs2_pkg::dp_ctl_t    ctl
);

  import cs2_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ctl_word_t       cw;
  logic            stall, take;

  // Fetch the control word of the current step.
  assign cw    = busy_r ? ucode_rom(pc_r) : '0;
  assign stall = (cw.emit != EM_NONE) && out_hold;

  assign ctl.cw   = cw;
  assign ctl.en   = busy_r & ~stall;
  assign in_ready = ~busy_r;

  // Jump condition from datapath status.
  always_comb begin
    unique case (cw.cond)
      C_NEXT:   take = 1'b0;
      C_N_MORE: take = ~status.n_last;
      C_R_ZERO: take = status.r_zero;
      C_R_MORE: take = ~status.r_one;
    endcase
  end

  // Program counter and busy flag.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (in_acc) begin
        busy_nxt = 1'b1;
        pc_nxt   = entry_pc(in_func);
      end
    end else if (ctl.en) begin
      if (cw.done) begin
        busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

// ===== rtl/rc4_multiround_keystream_xor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_multiround_keystream_xor_unit
// CipherSaber-2 byte cipher: key load, repeated RC4 key schedule, keystream
// XOR and wipe, run by a microcoded sequencer over one permutation RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_t*: in_tuser holds the function (load key
//   byte, run schedule, transform byte, wipe), in_tdata the key index and the
//   byte. Results leave on out_t*: out_tdata is the byte, out_tuser its kind.
//   A load gives no result; the other functions give exactly one.
//   Registers are written through cfg_we / cfg_addr / cfg_wdata by the user
//   only while idle; the block itself does not enforce it. Index 0 is the
//   pass count, index 1 the key length.
// Programs: a schedule runs the identity fill, then for each permutation
//   entry a read, the j update, a second read and the two swap writes, and
//   a pass-count step per pass, all through the one permutation RAM.
//   The next request is taken in the cycle after a program ends, and the
//   unit takes no new request while a program runs. The RAM's one read and
//   one write port set the steps.
// Reset: the permutation reads as all zero, both indices are zero, the pass
//   count is 20 and the key length 26; the key store is undefined until
//   loaded. No clearing pass is needed.
// Stall: a finished result waits in the output register; a program that
//   emits holds at its final step until the slot frees and takes no request.
// ----------------------------------------------------------------------------
module rc4_multiround_keystream_xor_unit #(
  parameter int KEY_DEPTH = cs2_pkg::KEY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input request channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // [7:0] key_index, [15:8] in_byte
  input  logic [1:0]                     in_tuser,  // [1:0] func
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata, // [7:0] out_byte
  output logic [1:0]                     out_tuser, // [1:0] kind
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [cs2_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cs2_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import cs2_pkg::*;

  logic        in_acc, emit, out_hold;
  logic        out_valid_r;
  logic [7:0]  out_byte_r, res_byte;
  logic [1:0]  out_kind_r, res_kind;
  logic [15:0] rounds_r;
  logic [8:0]  key_len_r;
  dp_ctl_t     ctl;
  dp_status_t  status;

  assign in_acc = in_tvalid & in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r  <= ROUNDS_RST;
      key_len_r <= KEY_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ROUNDS:  rounds_r  <= cfg_wdata;
        CFG_KEY_LEN: key_len_r <= cfg_wdata[8:0];
      endcase
    end
  end

  cs2_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_func  (in_tuser),
    .out_hold (out_hold),
    .status   (status),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  cs2_dp #(.KEY_DEPTH(KEY_DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_acc       (in_acc),
    .in_key_index (in_tdata[7:0]),
    .in_data      (in_tdata[15:8]),
    .ctl          (ctl),
    .rounds       (rounds_r),
    .key_len      (key_len_r),
    .status       (status),
    .res_byte     (res_byte)
  );

  // Result kind from the emitting step.
  always_comb begin
    case (ctl.cw.emit)
      EM_SCHED: res_kind = KIND_SCHED;
      EM_WIPE:  res_kind = KIND_WIPE;
      default:  res_kind = KIND_DATA;
    endcase
  end

  assign emit     = ctl.en && (ctl.cw.emit != EM_NONE);
  assign out_hold = out_valid_r & ~out_tready;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= res_byte;
      out_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;

endmodule
